// ===== design/wfps_pkg.sv =====
`timescale 1ns / 1ps

package wfps_pkg;

  // Path set and credit format.
  localparam int PATHS       = 4;
  localparam int CREDIT_BITS = 40;
  localparam int WEIGHT_REGS = 4;

  localparam int PATH_IDX_W = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int PCNT_W     = 3;
  localparam int ACT_W      = ($clog2(PATHS + 1) > PCNT_W) ? $clog2(PATHS + 1) : PCNT_W;

  // Field widths.
  localparam int WEIGHT_W  = 9;
  localparam int TIME_W    = 32;
  localparam int LEN_W     = 16;
  localparam int PROD_W    = WEIGHT_W + LEN_W;
  localparam int PAY_SHIFT = 8;
  localparam int OUT_W     = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [CREDIT_BITS-1:0] credit_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam credit_t CREDIT_MAX = {1'b0, {(CREDIT_BITS - 1){1'b1}}};
  localparam credit_t CREDIT_MIN = {1'b1, {(CREDIT_BITS - 1){1'b0}}};

  // Register indices.
  localparam cfg_idx_t REG_PATH_COUNT     = 3'd0;
  localparam cfg_idx_t REG_WEIGHT0        = 3'd1;
  localparam cfg_idx_t REG_WEIGHT1        = 3'd2;
  localparam cfg_idx_t REG_WEIGHT2        = 3'd3;
  localparam cfg_idx_t REG_WEIGHT3        = 3'd4;
  localparam cfg_idx_t REG_RESET_INTERVAL = 3'd5;
  localparam cfg_idx_t REG_FLOWLET_GAP    = 3'd6;

  // Register reset values.
  localparam logic [PCNT_W-1:0]   PATH_COUNT_RST     = 3'd4;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST         = 9'd64;
  localparam logic [TIME_W-1:0]   RESET_INTERVAL_RST = 32'd1000000;
  localparam logic [TIME_W-1:0]   FLOWLET_GAP_RST    = 32'd1000;

endpackage

// ===== design/wfps_if.sv =====
`timescale 1ns / 1ps

// Packet descriptor channel.
interface wfps_in_if;
  import wfps_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] arrival_time;
  logic [LEN_W-1:0]  packet_length;

  modport source (output valid, output arrival_time, output packet_length, input ready);
  modport sink   (input valid, input arrival_time, input packet_length, output ready);
endinterface

// Path decision channel.
interface wfps_out_if;
  import wfps_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] path_index;

  modport source (output valid, output path_index, input ready);
  modport sink   (input valid, input path_index, output ready);
endinterface

// Register write channel.
interface wfps_cfg_if;
  import wfps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/weighted_flowlet_path_selector.sv =====
`timescale 1ns / 1ps

// Weighted flowlet path selector. Each packet word carries an arrival time and a length
// in bytes; the block keeps a signed saturating credit per path (1/256-byte units), adds
// weight times length to every active path, switches to the path with the largest credit
// (lowest index on ties) when the idle gap since the previous packet exceeds flowlet_gap,
// charges the chosen path length times 256, and returns one word holding the path index.
// All credits are cleared when more than reset_interval ticks have passed since the last
// clearing. A packet passes from the accepting state through the time checks, a multiply
// and an add per path through the shared multiplier and saturating adder, the charge,
// and the loading of the result register, which waits while an earlier decision is still
// waiting to be taken. in_ch.ready is high only while no packet is in progress. The result
// register lets the next packet be accepted while a decision still waits to be taken;
// register writes are always accepted and must only be made while the block is idle.
module weighted_flowlet_path_selector (
  input logic        clk,
  input logic        rst_n,
  wfps_in_if.sink    in_ch,
  wfps_out_if.source out_ch,
  wfps_cfg_if.sink   cfg_ch
);
  import wfps_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_PAY   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Control state.
  logic [2:0]          state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Configuration registers.
  logic [PCNT_W-1:0]   path_count_r, path_count_nxt;
  logic [WEIGHT_W-1:0] weight_r [WEIGHT_REGS];
  logic [WEIGHT_W-1:0] weight_nxt [WEIGHT_REGS];
  logic [TIME_W-1:0]   reset_interval_r, reset_interval_nxt;
  logic [TIME_W-1:0]   flowlet_gap_r, flowlet_gap_nxt;

  // Architectural state.
  credit_t               credit_r [PATHS];
  credit_t               credit_nxt [PATHS];
  logic [TIME_W-1:0]     last_reset_r, last_reset_nxt;
  logic [TIME_W-1:0]     last_arrival_r, last_arrival_nxt;
  logic [PATH_IDX_W-1:0] current_path_r, current_path_nxt;

  // Working registers of the packet in progress.
  logic [TIME_W-1:0]     t_r, t_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [PATH_IDX_W-1:0] idx_r, idx_nxt;
  logic [PATH_IDX_W-1:0] best_idx_r, best_idx_nxt;
  credit_t               best_cred_r, best_cred_nxt;
  logic                  reset_hit_r, reset_hit_nxt;
  logic                  gap_hit_r, gap_hit_nxt;
  logic [OUT_W-1:0]      out_path_r, out_path_nxt;

  // Shared datapath.
  logic [ACT_W-1:0]              pcnt_ext;
  logic [ACT_W-1:0]              act_n;
  logic                          idx_act;
  logic [WEIGHT_W-1:0]           w_sel;
  logic [PROD_W-1:0]             prod_in;
  credit_t                       credit_rd;
  credit_t                       base;
  logic signed [CREDIT_BITS:0]   delta;
  logic signed [CREDIT_BITS:0]   sum;
  credit_t                       sat_res;
  logic                          new_better;
  logic                          last_path;
  logic [TIME_W-1:0]             since_reset;
  logic [TIME_W-1:0]             since_arrival;
  logic [PATH_IDX_W+OUT_W-1:0]   cp_ext;
  logic [PATH_IDX_W-1:0]         chosen;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.path_index = out_path_r;

  // A path count of zero behaves as one; counts above the number of paths are clipped.
  assign pcnt_ext = ACT_W'(path_count_r);
  always_comb begin
    if (pcnt_ext == '0) begin
      act_n = ACT_W'(1);
    end else if (pcnt_ext > ACT_W'(PATHS)) begin
      act_n = ACT_W'(PATHS);
    end else begin
      act_n = pcnt_ext;
    end
  end

  assign idx_act   = (ACT_W'(idx_r) < act_n);
  assign last_path = (idx_r == PATH_IDX_W'(PATHS - 1));

  // Paths without a weight register accrue nothing.
  always_comb begin
    w_sel = '0;
    for (int j = 0; j < WEIGHT_REGS; j++) begin
      if (int'(idx_r) == j) begin
        w_sel = weight_r[j];
      end
    end
  end

  assign prod_in = idx_act ? (PROD_W'(w_sel) * PROD_W'(len_r)) : '0;

  // The saturating adder serves both the accrual and the charge of the chosen path.
  assign credit_rd = credit_r[idx_r];
  assign base      = (state_r == S_ADD && reset_hit_r) ? '0 : credit_rd;

  always_comb begin
    if (state_r == S_PAY) begin
      delta = -$signed((CREDIT_BITS + 1)'({len_r, {PAY_SHIFT{1'b0}}}));
    end else begin
      delta = $signed((CREDIT_BITS + 1)'(prod_r));
    end
  end

  assign sum = $signed({base[CREDIT_BITS-1], base}) + delta;

  always_comb begin
    if (sum[CREDIT_BITS] != sum[CREDIT_BITS-1]) begin
      sat_res = sum[CREDIT_BITS] ? CREDIT_MIN : CREDIT_MAX;
    end else begin
      sat_res = sum[CREDIT_BITS-1:0];
    end
  end

  // The first path always seeds the search; later ones win only when strictly larger.
  assign new_better = (idx_r == '0) || (idx_act && (sat_res > best_cred_r));
  assign chosen     = new_better ? idx_r : best_idx_r;

  assign since_reset   = t_r - last_reset_r;
  assign since_arrival = t_r - last_arrival_r;
  assign cp_ext        = {{OUT_W{1'b0}}, current_path_r};

  // Register writes; an index beyond the list is ignored.
  always_comb begin
    path_count_nxt     = path_count_r;
    weight_nxt         = weight_r;
    reset_interval_nxt = reset_interval_r;
    flowlet_gap_nxt    = flowlet_gap_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PATH_COUNT:     path_count_nxt     = cfg_ch.data[PCNT_W-1:0];
        REG_WEIGHT0:        weight_nxt[0]      = cfg_ch.data[WEIGHT_W-1:0];
        REG_WEIGHT1:        weight_nxt[1]      = cfg_ch.data[WEIGHT_W-1:0];
        REG_WEIGHT2:        weight_nxt[2]      = cfg_ch.data[WEIGHT_W-1:0];
        REG_WEIGHT3:        weight_nxt[3]      = cfg_ch.data[WEIGHT_W-1:0];
        REG_RESET_INTERVAL: reset_interval_nxt = cfg_ch.data[TIME_W-1:0];
        REG_FLOWLET_GAP:    flowlet_gap_nxt    = cfg_ch.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: time checks, then multiply and add for every path in turn, then the charge.
  always_comb begin
    state_nxt        = state_r;
    out_valid_nxt    = out_valid_r;
    out_path_nxt     = out_path_r;
    credit_nxt       = credit_r;
    last_reset_nxt   = last_reset_r;
    last_arrival_nxt = last_arrival_r;
    current_path_nxt = current_path_r;
    t_nxt            = t_r;
    len_nxt          = len_r;
    prod_nxt         = prod_r;
    idx_nxt          = idx_r;
    best_idx_nxt     = best_idx_r;
    best_cred_nxt    = best_cred_r;
    reset_hit_nxt    = reset_hit_r;
    gap_hit_nxt      = gap_hit_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          t_nxt     = in_ch.arrival_time;
          len_nxt   = in_ch.packet_length;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        reset_hit_nxt    = (since_reset > reset_interval_r);
        gap_hit_nxt      = (since_arrival > flowlet_gap_r);
        if (since_reset > reset_interval_r) begin
          last_reset_nxt = t_r;
        end
        last_arrival_nxt = t_r;
        idx_nxt          = '0;
        state_nxt        = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = prod_in;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        // Every path is written back so that a pending clear reaches inactive paths too.
        credit_nxt[idx_r] = sat_res;
        if (new_better) begin
          best_idx_nxt  = idx_r;
          best_cred_nxt = sat_res;
        end
        if (last_path) begin
          if (gap_hit_r) begin
            current_path_nxt = chosen;
            idx_nxt          = chosen;
          end else begin
            idx_nxt          = current_path_r;
          end
          state_nxt = S_PAY;
        end else begin
          idx_nxt   = idx_r + PATH_IDX_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_PAY: begin
        credit_nxt[idx_r] = sat_res;
        state_nxt         = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_path_nxt  = cp_ext[OUT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      path_count_r     <= PATH_COUNT_RST;
      for (int j = 0; j < WEIGHT_REGS; j++) begin
        weight_r[j] <= WEIGHT_RST;
      end
      reset_interval_r <= RESET_INTERVAL_RST;
      flowlet_gap_r    <= FLOWLET_GAP_RST;
      for (int j = 0; j < PATHS; j++) begin
        credit_r[j] <= '0;
      end
      last_reset_r     <= '0;
      last_arrival_r   <= '0;
      current_path_r   <= '0;
    end else begin
      state_r          <= state_nxt;
      out_valid_r      <= out_valid_nxt;
      path_count_r     <= path_count_nxt;
      weight_r         <= weight_nxt;
      reset_interval_r <= reset_interval_nxt;
      flowlet_gap_r    <= flowlet_gap_nxt;
      credit_r         <= credit_nxt;
      last_reset_r     <= last_reset_nxt;
      last_arrival_r   <= last_arrival_nxt;
      current_path_r   <= current_path_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    len_r       <= len_nxt;
    prod_r      <= prod_nxt;
    idx_r       <= idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cred_r <= best_cred_nxt;
    reset_hit_r <= reset_hit_nxt;
    gap_hit_r   <= gap_hit_nxt;
    out_path_r  <= out_path_nxt;
  end

`ifndef SYNTHESIS
  // The current path always names an existing path.
  a_path_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(current_path_r) < PATHS)
    else $error("current path beyond the path set");

  // A flowlet switch lands on an active path.
  a_switch_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && last_path && gap_hit_r) |=> (ACT_W'(current_path_r) < act_n))
    else $error("flowlet switch chose an inactive path");

  // The charge follows the last accrual step and is made on the current path.
  a_pay_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAY) |-> ($past(state_r) == S_ADD && idx_r == current_path_r))
    else $error("charge step out of sequence");
`endif

endmodule
